@@ rtl/core/rau_pkg.sv @@
// Package for the rational arithmetic unit: operation codes, status codes,
// sequencer states and shared widths. No dependencies.
package rau_pkg;

	localparam int WIDE_W = 64;

	typedef enum logic [2:0] {
		FUNC_ADD = 3'd0,
		FUNC_SUB = 3'd1,
		FUNC_MUL = 3'd2,
		FUNC_DIV = 3'd3,
		FUNC_EQ  = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DIV0 = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_COMB,
		S_GSTRIP,
		S_GLOOP,
		S_DIVN,
		S_DIVD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
	} div_ctl_t;

endpackage

@@ rtl/core/rau_if.sv @@
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface rau_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/rau_div.sv @@
// Restoring divider, one quotient bit a cycle, for exact 64-bit division.
// Depends on rau_pkg for the shared width and the control struct.
module rau_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rau_pkg::WIDE_W-1:0]    dividend,
	input  logic [rau_pkg::WIDE_W-1:0]    divisor,
	output rau_pkg::div_ctl_t             ctl,
	output logic [rau_pkg::WIDE_W-1:0]    quotient
);
	localparam int CW = $clog2(rau_pkg::WIDE_W + 1);

	logic [rau_pkg::WIDE_W-1:0] rem_q, quo_q, dvs_q;
	logic [CW-1:0]              cnt_q;
	logic [rau_pkg::WIDE_W:0]   trial;
	logic [rau_pkg::WIDE_W:0]   shifted;

	assign shifted = {rem_q, quo_q[rau_pkg::WIDE_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(rau_pkg::WIDE_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!trial[rau_pkg::WIDE_W]) begin
				rem_q <= trial[rau_pkg::WIDE_W-1:0];
				quo_q <= {quo_q[rau_pkg::WIDE_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[rau_pkg::WIDE_W-1:0];
				quo_q <= {quo_q[rau_pkg::WIDE_W-2:0], 1'b0};
			end
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = (cnt_q != '0);
	assign quotient  = quo_q;
endmodule

@@ rtl/core/rational_arith_unit.sv @@
// Rational arithmetic unit: add, subtract, multiply, divide or compare two fractions.
// Equality, undefined codes and operand errors go to done from the first state, a zero
// numerator from the gcd strip state; other requests run the binary gcd and then two exact
// divisions, numerator first, in the shared divider.
// One request at a time: a new request is taken the cycle after the result has left.
// Reset (arst_n low, asynchronous) returns the sequencer to idle and drops valid.
module rational_arith_unit #(
	parameter int DATA_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	rau_if.sink   in_ch,
	rau_if.source out_ch
);
	localparam int W = rau_pkg::WIDE_W;

	// Input payload layout: func, a_num, a_den, b_num, b_den.
	// Output payload layout: res_num, res_den, equal, status.

	rau_pkg::state_t state_q, state_d;

	logic [2:0]  func_q;
	logic [31:0] an_q, bn_q;
	logic [30:0] ad_q, bd_q;

	// Products are formed with one signed 33x33 multiplier used three times.
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic signed [W-1:0] p1_q, p2_q;
	logic [W-1:0] nm_q, dm_q, gx_q, gy_q, g_q;
	logic [5:0]   sh_q;
	logic         neg_q;
	logic [31:0]  rn_q;
	logic [30:0]  rd_q;
	logic         eq_q;
	logic [1:0]   st_q;
	logic         out_v_q;
	logic         div_go_q;

	logic          div_start;
	logic [W-1:0]  div_dvd;
	rau_pkg::div_ctl_t div_ctl;
	logic [W-1:0]  div_quo;

	logic signed [W-1:0] n_full;
	logic [W-1:0] lim;
	logic [W-1:0] gdiff;

	assign lim = W'(1) << (DATA_WIDTH - 1);

	rau_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (g_q),
		.ctl      (div_ctl),
		.quotient (div_quo)
	);

	assign in_ch.ready = (state_q == rau_pkg::S_IDLE) && !out_v_q;
	assign out_ch.valid = out_v_q;
	assign out_ch.payload = {rn_q, rd_q, eq_q, st_q};

	// Multiplier operand selection: the first pass forms a_num*b_den, the second
	// a_num*b_num or b_num*a_den, the third the denominator a_den*b_den or a_den*b_num.
	always_comb begin
		mul_a = {an_q[31], an_q};
		mul_b = {2'b00, bd_q};
		if (state_q == rau_pkg::S_MUL2) begin
			unique case (func_q)
				rau_pkg::FUNC_MUL: begin
					mul_a = {an_q[31], an_q};
					mul_b = {bn_q[31], bn_q};
				end
				default: begin
					mul_a = {bn_q[31], bn_q};
					mul_b = {2'b00, ad_q};
				end
			endcase
		end else if (state_q == rau_pkg::S_COMB) begin
			mul_a = {2'b00, ad_q};
			mul_b = (func_q == rau_pkg::FUNC_DIV) ? {bn_q[31], bn_q} : {2'b00, bd_q};
		end
	end
	assign mul_p = mul_a * mul_b;

	always_comb begin
		case (func_q)
			rau_pkg::FUNC_ADD: n_full = p1_q + p2_q;
			rau_pkg::FUNC_SUB: n_full = p1_q - p2_q;
			rau_pkg::FUNC_MUL: n_full = p2_q;
			default:           n_full = p1_q;
		endcase
	end

	assign gdiff   = (gx_q > gy_q) ? gx_q - gy_q : gy_q - gx_q;
	// The divider is started from a register set at the same edge as the divisor or the
	// numerator quotient: first with the numerator, then the denominator.
	assign div_start = div_go_q;
	assign div_dvd = (state_q == rau_pkg::S_DIVN) ? nm_q : dm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rau_pkg::S_IDLE;
			out_v_q  <= 1'b0;
			div_go_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			div_go_q <= (state_q == rau_pkg::S_GLOOP && gy_q == '0) ||
				(state_q == rau_pkg::S_DIVN && !div_ctl.busy && !div_ctl.start);
			if (out_ch.valid && out_ch.ready) begin
				out_v_q <= 1'b0;
			end else if (state_q == rau_pkg::S_DONE) begin
				out_v_q <= 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rau_pkg::S_IDLE:   if (in_ch.valid && in_ch.ready) state_d = rau_pkg::S_MUL1;
			rau_pkg::S_MUL1: begin
				if (func_q > 3'(rau_pkg::FUNC_DIV) || ad_q == '0 || bd_q == '0 ||
					(func_q == rau_pkg::FUNC_DIV && bn_q == '0)) begin
					state_d = rau_pkg::S_DONE;
				end else begin
					state_d = rau_pkg::S_MUL2;
				end
			end
			rau_pkg::S_MUL2:   state_d = rau_pkg::S_COMB;
			rau_pkg::S_COMB:   state_d = rau_pkg::S_GSTRIP;
			rau_pkg::S_GSTRIP: begin
				if (nm_q == '0) state_d = rau_pkg::S_DONE;
				else if (gx_q[0] || gy_q[0]) state_d = rau_pkg::S_GLOOP;
			end
			rau_pkg::S_GLOOP:  if (gy_q == '0) state_d = rau_pkg::S_DIVN;
			rau_pkg::S_DIVN:   if (!div_ctl.busy && !div_ctl.start) state_d = rau_pkg::S_DIVD;
			rau_pkg::S_DIVD:   if (!div_ctl.busy && !div_ctl.start) state_d = rau_pkg::S_DONE;
			rau_pkg::S_DONE:   state_d = rau_pkg::S_IDLE;
			default:           state_d = rau_pkg::S_IDLE;
		endcase
	end

	// Datapath registers.  sh_q holds the common power of two of the gcd.
	// The result fields are cleared only when a new request is taken, so a
	// waiting result holds its value.
	always_ff @(posedge clk) begin
		unique case (state_q)
			rau_pkg::S_IDLE: begin
				if (in_ch.valid && in_ch.ready) begin
					{func_q, an_q, ad_q, bn_q, bd_q} <= in_ch.payload;
					rn_q <= '0; rd_q <= '0; eq_q <= 1'b0; st_q <= rau_pkg::ST_OK;
				end
			end
			rau_pkg::S_MUL1: begin
				p1_q <= W'(mul_p);
				if (func_q == rau_pkg::FUNC_EQ) eq_q <= (an_q == bn_q) && (ad_q == bd_q);
				else if (func_q <= 3'(rau_pkg::FUNC_DIV) && (ad_q == '0 || bd_q == '0 ||
					(func_q == rau_pkg::FUNC_DIV && bn_q == '0))) st_q <= rau_pkg::ST_DIV0;
			end
			rau_pkg::S_MUL2: p2_q <= W'(mul_p);
			rau_pkg::S_COMB: begin
				nm_q  <= n_full[W-1] ? W'(0) - W'(n_full) : W'(n_full);
				dm_q  <= mul_p[65] ? W'(0) - W'(mul_p) : W'(mul_p);
				gx_q  <= n_full[W-1] ? W'(0) - W'(n_full) : W'(n_full);
				gy_q  <= mul_p[65] ? W'(0) - W'(mul_p) : W'(mul_p);
				neg_q <= n_full[W-1] ^ mul_p[65];
				sh_q  <= '0;
			end
			rau_pkg::S_GSTRIP: begin
				if (nm_q == '0) begin
					rn_q <= '0; rd_q <= 31'd1;
				end else if (!gx_q[0] && !gy_q[0]) begin
					gx_q <= gx_q >> 1; gy_q <= gy_q >> 1; sh_q <= sh_q + 6'd1;
				end
			end
			rau_pkg::S_GLOOP: begin
				if (gy_q == '0) begin
					g_q <= gx_q << sh_q;
				end else if (!gx_q[0]) begin
					gx_q <= gx_q >> 1;
				end else if (!gy_q[0]) begin
					gy_q <= gy_q >> 1;
				end else begin
					gx_q <= (gx_q < gy_q) ? gx_q : gy_q;
					gy_q <= gdiff;
				end
			end
			rau_pkg::S_DIVN: begin
				// The divider was started with the numerator on entering this state.
				if (!div_ctl.busy && !div_ctl.start) begin
					nm_q <= div_quo;
				end
			end
			rau_pkg::S_DIVD: begin
				if (!div_ctl.busy && !div_ctl.start) begin
					if (div_quo > lim - 1 || (neg_q ? nm_q > lim : nm_q > lim - 1)) begin
						st_q <= rau_pkg::ST_OVF;
					end else begin
						rn_q <= 32'(neg_q ? W'(0) - nm_q : nm_q);
						rd_q <= 31'(div_quo);
					end
				end
			end
			default: ;
		endcase
	end
endmodule

@@ rtl/core/rau_checker.sv @@
// Port-level checker for the rational arithmetic unit, bound to the top level.
// Depends on rau_pkg for status codes.
module rau_assertions (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [65:0] out_payload
);
	// No new request while a result waits.
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("request taken while result pending");
	// No result is valid in the cycle after a request is taken.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid) else $error("result too early");
	// Status never takes the unused code.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_payload[1:0] != 2'd3) else $error("bad status");
	// A failed operation carries zero fields.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_payload[1:0] != rau_pkg::ST_OK) |-> out_payload[65:2] == '0)
		else $error("error result with data");
	// Stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(out_payload))
		else $error("result changed under stall");
endmodule

bind rational_arith_unit rau_assertions u_rau_assertions (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_payload (out_ch.payload)
);

@@ bench/rau_test_pkg.sv @@
// Request and result layouts carried on the two channels of the rational unit bench.
// Depends on rau_pkg for the operation and status codes.
package rau_test_pkg;
	import rau_pkg::*;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] a_num;
		logic [30:0] a_den;
		logic [31:0] b_num;
		logic [30:0] b_den;
	} rau_req_t;

	typedef struct packed {
		logic [31:0] res_num;
		logic [30:0] res_den;
		logic        equal;
		logic [1:0]  status;
	} rau_rsp_t;

	// Codes past the last defined operation; the unit answers them with all zeros.
	localparam logic [2:0] FUNC_UNDEF_FIRST = 3'd5;
	localparam logic [2:0] FUNC_UNDEF_LAST  = 3'd7;
endpackage

@@ bench/rau_checker.sv @@
// Watches both channels of the rational unit, predicts each result and compares it.
// Depends on rau_pkg and rau_test_pkg.
module rau_checker #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  rau_test_pkg::rau_req_t  in_payload,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  rau_test_pkg::rau_rsp_t  out_payload,
	output int                      errors,
	output int                      pending
);
	import rau_pkg::*;
	import rau_test_pkg::*;

	rau_rsp_t expected_results[$];

	function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
		longint unsigned t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic rau_rsp_t fraction_result(rau_req_t r);
		rau_rsp_t o;
		longint an, ad, bn, bd, n, d;
		longint unsigned nm, dm, g, lim;
		bit nneg, dneg, neg;
		o = '0;
		an = longint'($signed(r.a_num));
		bn = longint'($signed(r.b_num));
		ad = longint'({1'b0, r.a_den});
		bd = longint'({1'b0, r.b_den});
		if (r.func == FUNC_EQ) begin
			o.equal = (an == bn) && (ad == bd);
			return o;
		end
		if (r.func > FUNC_EQ)
			return o;
		if (ad == 0 || bd == 0 || (r.func == FUNC_DIV && bn == 0)) begin
			o.status = ST_DIV0;
			return o;
		end
		case (r.func)
			FUNC_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
			FUNC_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
			FUNC_MUL: begin n = an * bn; d = ad * bd; end
			default:  begin n = an * bd; d = ad * bn; end
		endcase
		nneg = n < 0;
		dneg = d < 0;
		neg = nneg != dneg;
		nm = nneg ? -n : n;
		dm = dneg ? -d : d;
		lim = 64'd1 << (DATA_WIDTH - 1);
		if (nm == 0) begin
			o.res_den = 31'd1;
			return o;
		end
		g = gcd_of(nm, dm);
		nm = nm / g;
		dm = dm / g;
		if (dm > lim - 1 || (neg ? nm > lim : nm > lim - 1))
			o.status = ST_OVF;
		else begin
			o.res_num = neg ? 32'(-nm) : 32'(nm);
			o.res_den = 31'(dm);
		end
		return o;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		rau_rsp_t want;
		if (!arst_n) begin
			errors <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_results.push_back(fraction_result(in_payload));
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding");
					errors <= errors + 1;
				end else begin
					want = expected_results.pop_front();
					if (out_payload !== want) begin
						if (out_payload.res_num !== want.res_num)
							$error("res_num expected %0d got %0d",
								$signed(want.res_num), $signed(out_payload.res_num));
						if (out_payload.res_den !== want.res_den)
							$error("res_den expected %0d got %0d",
								want.res_den, out_payload.res_den);
						if (out_payload.equal !== want.equal)
							$error("equal expected %0d got %0d", want.equal, out_payload.equal);
						if (out_payload.status !== want.status)
							$error("status expected %0d got %0d", want.status, out_payload.status);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

@@ bench/rational_arith_unit_test.sv @@
// Top of the rational unit bench: clock, reset, request stimulus and the verdict.
// Depends on rau_pkg, rau_test_pkg, rau_if, rau_checker and the unit itself.
module rational_arith_unit_test;
	import rau_pkg::*;
	import rau_test_pkg::*;

	// The cycle limit is several times the slowest honest run of about two thousand requests.
	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_PER_PHASE = 617;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   cycles = 0;
	int   send_idle_pct = 11;
	int   recv_stall_pct = 52;
	int   errors;
	int   pending;

	rau_if #(.payload_t(rau_req_t)) in_ch ();
	rau_if #(.payload_t(rau_rsp_t)) out_ch ();

	rational_arith_unit #(.DATA_WIDTH(32)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	rau_checker #(.DATA_WIDTH(32)) chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_ch.valid),
		.in_ready    (in_ch.ready),
		.in_payload  (in_ch.payload),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.out_payload (out_ch.payload),
		.errors      (errors),
		.pending     (pending)
	);

	always #10 clk = ~clk;

	// The result side stalls at random with the current percentage, one update per edge,
	// and stays stalled while reset is held.
	always @(posedge clk) begin
		out_ch.ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Present one request and hold it until the unit takes it. Ready changes only just
	// after a rising edge, so its value at the falling edge is the one the next rising
	// edge sees. A random idle gap may be inserted before the request goes out.
	task automatic send_request(rau_req_t r);
		if ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.payload <= r;
		forever begin
			@(negedge clk);
			if (in_ch.ready) break;
		end
		@(posedge clk);
	endtask

	function automatic rau_req_t make_request(logic [2:0] f, int an, int ad, int bn, int bd);
		rau_req_t r;
		r.func = f;
		r.a_num = an;
		r.a_den = ad[30:0];
		r.b_num = bn;
		r.b_den = bd[30:0];
		return r;
	endfunction

	// Operand value: mostly small so that results fit, sometimes full width,
	// sometimes at the edges of the field.
	function automatic logic [31:0] random_numerator();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return 32'($signed($urandom_range(2000)) - 1000);
			5:             return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
			6:             return 32'd0;
			default:       return $urandom;
		endcase
	endfunction

	function automatic logic [30:0] random_denominator();
		case ($urandom_range(19))
			0:       return 31'd0;
			1:       return 31'h7fff_ffff;
			2, 3:    return 31'($urandom);
			default: return 31'($urandom_range(1000, 1));
		endcase
	endfunction

	function automatic rau_req_t random_request();
		rau_req_t r;
		int pick;
		pick = $urandom_range(99);
		if (pick < 4)
			r.func = 3'($urandom_range(FUNC_UNDEF_LAST, FUNC_UNDEF_FIRST));
		else
			r.func = 3'($urandom_range(FUNC_EQ, FUNC_ADD));
		r.a_num = random_numerator();
		r.a_den = random_denominator();
		// Equality wants matches now and then, or it would almost always say no.
		if (r.func == FUNC_EQ && $urandom_range(1)) begin
			r.b_num = r.a_num;
			r.b_den = r.a_den;
		end else begin
			r.b_num = random_numerator();
			r.b_den = random_denominator();
		end
		return r;
	endfunction

	task automatic random_phase(int idle_pct, int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (RANDOM_PER_PHASE) send_request(random_request());
	endtask

	initial begin
		rau_req_t directed[$];
		// Inputs start known; the stimulus takes over once reset has been released.
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests: every operation, field extremes and the special cases.
		directed.push_back(make_request(FUNC_ADD, 1, 2, 1, 3));
		directed.push_back(make_request(FUNC_SUB, 1, 2, 1, 2));           // zero gives 0/1
		directed.push_back(make_request(FUNC_MUL, -3, 4, 2, 9));
		directed.push_back(make_request(FUNC_DIV, 5, 7, -10, 21));
		directed.push_back(make_request(FUNC_DIV, 5, 7, 0, 1));           // zero divisor
		directed.push_back(make_request(FUNC_ADD, 1, 0, 1, 1));           // zero denominators
		directed.push_back(make_request(FUNC_SUB, 1, 1, 1, 0));
		directed.push_back(make_request(FUNC_MUL, 0, 0, 3, 5));
		directed.push_back(make_request(FUNC_DIV, 2, 3, 4, 0));
		directed.push_back(make_request(FUNC_EQ, 7, 0, 7, 0));            // raw compare
		directed.push_back(make_request(FUNC_EQ, 2, 4, 1, 2));            // not reduced, unequal
		directed.push_back(make_request(FUNC_EQ, 32'h8000_0000, 32'h7fff_ffff,
			32'h8000_0000, 32'h7fff_ffff));
		directed.push_back(make_request(FUNC_UNDEF_FIRST, 1, 1, 1, 1));
		directed.push_back(make_request(3'(FUNC_UNDEF_FIRST + 1), -1, 5, 2, 7));
		directed.push_back(make_request(FUNC_UNDEF_LAST, 32'hffff_ffff, 32'h7fff_ffff,
			32'hffff_ffff, 32'h7fff_ffff));
		directed.push_back(make_request(FUNC_ADD, 2, 4, 6, 12));          // unreduced operands
		directed.push_back(make_request(FUNC_MUL, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1));
		directed.push_back(make_request(FUNC_MUL, 32'h8000_0000, 1, 1, 1)); // most negative fits
		directed.push_back(make_request(FUNC_MUL, 32'h8000_0000, 1, -1, 1)); // just overflows
		directed.push_back(make_request(FUNC_ADD, 32'h8000_0000, 32'h7fff_ffff,
			32'h8000_0000, 32'h7ffffffe));
		directed.push_back(make_request(FUNC_SUB, 32'h7fff_ffff, 1, 32'h8000_0000, 1));
		directed.push_back(make_request(FUNC_DIV, 1, 32'h7fff_ffff, 1, 32'h7fff_ffff));
		directed.push_back(make_request(FUNC_DIV, 32'h8000_0000, 1, -1, 32'h7fff_ffff));
		foreach (directed[i]) send_request(directed[i]);

		// Hold off until the unit has caught up completely, then go on. The falling
		// edge lets the checker record the last request before the count is read.
		in_ch.valid <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
		@(posedge clk);

		random_phase(11, 52);
		random_phase(52, 11);
		random_phase(0, 0);

		in_ch.valid <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
